### hw/rtl/e2k_pkg.sv
package e2k_pkg;

  localparam int AngW = 32;
  localparam logic [AngW-1:0] HalfTurn = 32'h8000_0000;
  localparam logic [AngW-1:0] QuarterTurn = 32'h4000_0000;
  localparam logic [63:0] OneQ24 = 64'd16777216;
  localparam logic [31:0] EccMax = 32'hFFFF_FFFF;

  // Arctangent table in binary angle units, zero beyond stage 30.
  function automatic logic [31:0] atan_entry(input int s);
    logic [31:0] t;
    case (s)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

### hw/rtl/equinoctial_to_keplerian_elements.sv
// Equinoctial to Keplerian element converter.
// The input channel takes one element set (axis_in, h_comp, k_comp, p_comp,
// q_comp, mean_longitude) per request when in_valid is high and in_stall low.
// The output channel presents one Keplerian set per request on out_valid;
// the receiver holds it with out_stall.
// The datapath is a row of pipeline cells: squaring, 32 square root cells,
// rounding, then CORDIC_STAGES CORDIC cells for the inclination, while the
// node and perihelion-longitude CORDIC rows run alongside, and two final
// stages for clamping and angle differences.
// Throughput is one request per cycle while the receiver does not stall; all stages advance together.
// When the receiver stalls with a result waiting, the whole row freezes and
// in_stall rises; when the output is empty or taken, input is accepted.
// Synchronous reset empties the row (all valid flags clear); data
// registers are not reset.
module equinoctial_to_keplerian_elements import e2k_pkg::*; #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] axis_in,
  input  logic signed [31:0] h_comp,
  input  logic signed [31:0] k_comp,
  input  logic signed [31:0] p_comp,
  input  logic signed [31:0] q_comp,
  input  logic [31:0] mean_longitude,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] axis_out,
  output logic [31:0] ecc_out,
  output logic [31:0] incl_out,
  output logic [31:0] node_out,
  output logic [31:0] periapsis_arg_out,
  output logic [31:0] anomaly_out
);
  localparam int SqN = 32;
  localparam int Depth = CORDIC_STAGES + 36;
  localparam int Side = SqN + 2;

  logic en;
  logic [Depth-1:0] vld;
  assign en = !(vld[Depth-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[Depth-1];

  // Valid bits move along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // Side data delayed to line up with the CORDIC rows.
  logic [47:0] ax_d [Side];
  logic [31:0] lam_d [Side];
  logic signed [31:0] h_d [Side];
  logic signed [31:0] k_d [Side];
  logic signed [31:0] p_d [Side];
  logic signed [31:0] q_d [Side];

  // Squares and sums.
  logic [63:0] hk_sq;
  logic [63:0] pq_sq;
  logic [63:0] hh, kk, pp, qq;
  logic [63:0] h_ab, k_ab, p_ab, q_ab;
  always_comb begin
    h_ab = 64'(h_comp[31] ? -64'(h_comp) : 64'(h_comp));
    k_ab = 64'(k_comp[31] ? -64'(k_comp) : 64'(k_comp));
    p_ab = 64'(p_comp[31] ? -64'(p_comp) : 64'(p_comp));
    q_ab = 64'(q_comp[31] ? -64'(q_comp) : 64'(q_comp));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      hh <= h_ab[32:0] * h_ab[32:0];
      kk <= k_ab[32:0] * k_ab[32:0];
      pp <= p_ab[32:0] * p_ab[32:0];
      qq <= q_ab[32:0] * q_ab[32:0];
      ax_d[0] <= axis_in;
      lam_d[0] <= mean_longitude;
      h_d[0] <= h_comp;
      k_d[0] <= k_comp;
      p_d[0] <= p_comp;
      q_d[0] <= q_comp;
    end
  end
  assign hk_sq = hh + kk;
  assign pq_sq = pp + qq;

  genvar g;
  for (g = 1; g < Side; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        ax_d[g] <= ax_d[g-1];
        lam_d[g] <= lam_d[g-1];
        h_d[g] <= h_d[g-1];
        k_d[g] <= k_d[g-1];
        p_d[g] <= p_d[g-1];
        q_d[g] <= q_d[g-1];
      end
    end
  end

  // Square root rows for both magnitudes.
  logic [63:0] ra [SqN+1];
  logic [65:0] ma [SqN+1];
  logic [32:0] oa [SqN+1];
  logic [63:0] rb [SqN+1];
  logic [65:0] mb [SqN+1];
  logic [32:0] ob [SqN+1];
  assign ra[0] = hk_sq;
  assign ma[0] = '0;
  assign oa[0] = '0;
  assign rb[0] = pq_sq;
  assign mb[0] = '0;
  assign ob[0] = '0;
  for (g = 0; g < SqN; g++) begin : g_sqrt
    e2k_sqrt_cell #(.Step(g)) u_a (
      .clk(clk), .en(en), .rad_in(ra[g]), .rem_in(ma[g]), .root_in(oa[g]),
      .rad_out(ra[g+1]), .rem_out(ma[g+1]), .root_out(oa[g+1]));
    e2k_sqrt_cell #(.Step(g)) u_b (
      .clk(clk), .en(en), .rad_in(rb[g]), .rem_in(mb[g]), .root_in(ob[g]),
      .rad_out(rb[g+1]), .rem_out(mb[g+1]), .root_out(ob[g+1]));
  end

  // Round to nearest: increment when remainder exceeds root.
  logic [32:0] ecc_r;
  logic [32:0] tan_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ecc_r <= oa[SqN] + 33'((ma[SqN] > 66'(oa[SqN])) ? 1 : 0);
      tan_r <= ob[SqN] + 33'((mb[SqN] > 66'(ob[SqN])) ? 1 : 0);
    end
  end

  // CORDIC start: zero vector and left half-plane handling.
  logic signed [63:0] ix [CORDIC_STAGES+1];
  logic signed [63:0] iy [CORDIC_STAGES+1];
  logic [31:0] ia [CORDIC_STAGES+1];
  logic signed [63:0] nx [CORDIC_STAGES+1];
  logic signed [63:0] ny [CORDIC_STAGES+1];
  logic [31:0] na [CORDIC_STAGES+1];
  logic signed [63:0] lx [CORDIC_STAGES+1];
  logic signed [63:0] ly [CORDIC_STAGES+1];
  logic [31:0] la [CORDIC_STAGES+1];
  logic nz [CORDIC_STAGES+1];
  logic lz [CORDIC_STAGES+1];
  logic [31:0] ecc_d [CORDIC_STAGES+1];

  always_comb begin
    logic signed [63:0] qs, ps, ks, hs;
    qs = 64'(q_d[Side-1]);
    ps = 64'(p_d[Side-1]);
    ks = 64'(k_d[Side-1]);
    hs = 64'(h_d[Side-1]);
    ix[0] = OneQ24;
    iy[0] = 64'(tan_r);
    ia[0] = '0;
    nx[0] = qs[63] ? -qs : qs;
    ny[0] = qs[63] ? -ps : ps;
    na[0] = qs[63] ? HalfTurn : '0;
    lx[0] = ks[63] ? -ks : ks;
    ly[0] = ks[63] ? -hs : hs;
    la[0] = ks[63] ? HalfTurn : '0;
    nz[0] = (qs == 0) && (ps == 0);
    lz[0] = (ks == 0) && (hs == 0);
    ecc_d[0] = ecc_r[32] ? EccMax : ecc_r[31:0];
  end

  logic [47:0] ax_c [CORDIC_STAGES+1];
  logic [31:0] lam_c [CORDIC_STAGES+1];
  assign ax_c[0] = ax_d[Side-1];
  assign lam_c[0] = lam_d[Side-1];

  for (g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    e2k_cordic_cell #(.Stage(g)) u_i (
      .clk(clk), .en(en), .x_in(ix[g]), .y_in(iy[g]), .ang_in(ia[g]),
      .x_out(ix[g+1]), .y_out(iy[g+1]), .ang_out(ia[g+1]));
    e2k_cordic_cell #(.Stage(g)) u_n (
      .clk(clk), .en(en), .x_in(nx[g]), .y_in(ny[g]), .ang_in(na[g]),
      .x_out(nx[g+1]), .y_out(ny[g+1]), .ang_out(na[g+1]));
    e2k_cordic_cell #(.Stage(g)) u_l (
      .clk(clk), .en(en), .x_in(lx[g]), .y_in(ly[g]), .ang_in(la[g]),
      .x_out(lx[g+1]), .y_out(ly[g+1]), .ang_out(la[g+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        nz[g+1] <= nz[g];
        lz[g+1] <= lz[g];
        ecc_d[g+1] <= ecc_d[g];
        ax_c[g+1] <= ax_c[g];
        lam_c[g+1] <= lam_c[g];
      end
    end
  end

  // Clamp inclination and resolve zero vectors.
  logic [31:0] hi_r, nd_r, pl_r, ec_r, lm_r;
  logic [47:0] ax_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (ia[CORDIC_STAGES] >= HalfTurn) begin
        hi_r <= '0;
      end else if (ia[CORDIC_STAGES] > QuarterTurn) begin
        hi_r <= QuarterTurn;
      end else begin
        hi_r <= ia[CORDIC_STAGES];
      end
      nd_r <= nz[CORDIC_STAGES] ? '0 : na[CORDIC_STAGES];
      pl_r <= lz[CORDIC_STAGES] ? '0 : la[CORDIC_STAGES];
      ec_r <= ecc_d[CORDIC_STAGES];
      lm_r <= lam_c[CORDIC_STAGES];
      ax_r <= ax_c[CORDIC_STAGES];
    end
  end

  // Output register with angle differences.
  always_ff @(posedge clk) begin
    if (en) begin
      axis_out <= ax_r;
      ecc_out <= ec_r;
      incl_out <= {hi_r[30:0], 1'b0};
      node_out <= nd_r;
      periapsis_arg_out <= pl_r - nd_r;
      anomaly_out <= lm_r - pl_r;
    end
  end
endmodule

### hw/rtl/e2k_sqrt_cell.sv
// One restoring square root step: two radicand bits consumed per cell.
module e2k_sqrt_cell import e2k_pkg::*; #(
  parameter int Step = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad_in,
  input  logic [65:0] rem_in,
  input  logic [32:0] root_in,
  output logic [63:0] rad_out,
  output logic [65:0] rem_out,
  output logic [32:0] root_out
);
  logic [65:0] trial;
  logic [65:0] rem_sh;

  // Bring down the next bit pair and try subtracting 4*root+1.
  always_comb begin
    rem_sh = {rem_in[63:0], rad_in[63-2*Step -: 2]};
    trial = rem_sh - {31'd0, root_in, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= rad_in;
      if (!trial[65]) begin
        rem_out <= trial;
        root_out <= {root_in[31:0], 1'b1};
      end else begin
        rem_out <= rem_sh;
        root_out <= {root_in[31:0], 1'b0};
      end
    end
  end
endmodule

### hw/rtl/e2k_cordic_cell.sv
// One CORDIC vectoring rotation stage with fixed shift.
module e2k_cordic_cell import e2k_pkg::*; #(
  parameter int Stage = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] x_in,
  input  logic signed [63:0] y_in,
  input  logic [31:0]        ang_in,
  output logic signed [63:0] x_out,
  output logic signed [63:0] y_out,
  output logic [31:0]        ang_out
);
  localparam int Sh = (Stage > 63) ? 63 : Stage;
  localparam logic [31:0] Tab = atan_entry(Stage);
  logic signed [63:0] dx;
  logic signed [63:0] dy;

  // Arithmetic shifts give floor division.
  always_comb begin
    dx = y_in >>> Sh;
    dy = x_in >>> Sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[63]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        ang_out <= ang_in + Tab;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        ang_out <= ang_in - Tab;
      end
    end
  end
endmodule
